### hw/rtl/kce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants of the canonical k-mer extractor
// Holds field widths, base codes and the classified item passed from the
// front end to the back end through the item queue.
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int CHAR_W = 8;
  localparam int READ_W = 32;
  localparam int KMER_W = 62;
  localparam int K_W    = 5;
  localparam int SHIFT_W = 6;

  localparam logic [K_W-1:0] K_RESET = 5'd23;
  localparam logic [K_W-1:0] RUN_MAX = 5'd31;

  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

  localparam logic [1:0] CODE_C = 2'd0;
  localparam logic [1:0] CODE_A = 2'd1;
  localparam logic [1:0] CODE_T = 2'd2;
  localparam logic [1:0] CODE_G = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [1:0]        code;
    logic              base_ok;
    logic              read_start;
    logic [READ_W-1:0] read_number;
  } base_item_t;

endpackage

### hw/rtl/kce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_front: input front end
// Accepts characters, maps each to its 2-bit base code and pushes the
// classified item into the item queue.
// ----------------------------------------------------------------------------
module kce_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [kce_pkg::CHAR_W-1:0] base_char,
  input  logic                      read_start,
  input  logic [kce_pkg::READ_W-1:0] read_number,
  input  logic                      queue_full,
  output logic                      push,
  output kce_pkg::base_item_t       push_item
);
  import kce_pkg::*;

  logic [1:0] code;
  logic       base_ok;

  always_comb begin
    base_ok = 1'b1;
    unique case (base_char)
      CHAR_C:  code = CODE_C;
      CHAR_A:  code = CODE_A;
      CHAR_T:  code = CODE_T;
      CHAR_G:  code = CODE_G;
      default: begin
        code    = CODE_C;
        base_ok = 1'b0;
      end
    endcase
  end

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  assign push_item.code        = code;
  assign push_item.base_ok     = base_ok;
  assign push_item.read_start  = read_start;
  assign push_item.read_number = read_number;

endmodule

### hw/rtl/kce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_queue: item queue
// A short first-in first-out queue that decouples the front end from the
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
module kce_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kce_pkg::base_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output kce_pkg::base_item_t head_item
);
  import kce_pkg::*;

  base_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/kce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kce_back: rolling window back end
// Shifts each base into the forward and reverse-complement windows, counts
// the run of valid bases and registers the canonical k-mer for output.
// ----------------------------------------------------------------------------
module kce_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  kce_pkg::base_item_t        item,
  output logic                       pop,
  input  logic                       cfg_valid,
  input  logic [kce_pkg::K_W-1:0]    cfg_k,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kce_pkg::KMER_W-1:0] canonical_kmer,
  output logic [kce_pkg::READ_W-1:0] kmer_read
);
  import kce_pkg::*;

  logic [K_W-1:0]     k_reg;
  logic [KMER_W-1:0]  fwd;
  logic [KMER_W-1:0]  rev;
  logic [K_W-1:0]     run;

  logic [K_W-1:0]     k_eff;
  logic [SHIFT_W-1:0] top_shift;
  logic [KMER_W-1:0]  mask;
  logic [KMER_W-1:0]  fwd_base;
  logic [KMER_W-1:0]  rev_base;
  logic [K_W-1:0]     run_base;
  logic [KMER_W-1:0]  fwd_next;
  logic [KMER_W-1:0]  rev_next;
  logic [K_W-1:0]     run_next;
  logic               emit;
  logic [KMER_W-1:0]  kmer_next;

  assign pop = item_valid && !cfg_valid && (!out_valid || out_ready);

  always_comb begin
    k_eff     = (k_reg == '0) ? K_W'(1) : k_reg;
    top_shift = {k_eff, 1'b0} - SHIFT_W'(2);
    mask      = ~({KMER_W{1'b1}} << {k_eff, 1'b0});
    fwd_base  = item.read_start ? '0 : fwd;
    rev_base  = item.read_start ? '0 : rev;
    run_base  = item.read_start ? '0 : run;
    fwd_next  = ((fwd_base << 2) | KMER_W'(item.code)) & mask;
    rev_next  = ((rev_base >> 2) | (KMER_W'(item.code ^ 2'b11) << top_shift)) & mask;
    run_next  = (run_base == RUN_MAX) ? RUN_MAX : run_base + K_W'(1);
    emit      = item.base_ok && (run_next >= k_eff);
    kmer_next = (fwd_next >= rev_next) ? fwd_next : rev_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg     <= K_RESET;
      fwd       <= '0;
      rev       <= '0;
      run       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        k_reg <= cfg_k;
        fwd   <= '0;
        rev   <= '0;
        run   <= '0;
      end else if (pop) begin
        if (item.base_ok) begin
          fwd <= fwd_next;
          rev <= rev_next;
          run <= run_next;
        end else begin
          fwd <= fwd_base;
          rev <= rev_base;
          run <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      canonical_kmer <= kmer_next;
      kmer_read      <= item.read_number;
    end
  end

endmodule

### hw/rtl/canonical_kmer_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_extractor_core: canonical k-mer extraction from DNA reads
// Input channel (in_valid/in_ready) takes one character per transaction with
// its start-of-read flag and read number. Output channel (out_valid/out_ready)
// delivers one canonical k-mer and its read number per transaction, once k
// consecutive valid bases A, C, G, T have been seen in the current read.
// Configuration channel (cfg_valid/cfg_ready) writes k; it is always ready and
// clears the windows; the user must use it only while idle (not enforced).
// An input character passes through the item queue and then the output
// register before its k-mer is offered; each adds one stage.
// Throughput is one character per cycle while the receiver does not stall and no
// cfg write is pending, set by the combinational window shift and compare.
// Reset sets k to 23, clears the windows and run count and empties the queue.
// When the receiver stalls, the output register holds its result, the back
// end stops, and the two-entry queue fills before in_ready drops.
// ----------------------------------------------------------------------------
module canonical_kmer_extractor_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kce_pkg::CHAR_W-1:0] base_char,
  input  logic                       read_start,
  input  logic [kce_pkg::READ_W-1:0] read_number,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kce_pkg::K_W-1:0]    kmer_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kce_pkg::KMER_W-1:0] canonical_kmer,
  output logic [kce_pkg::READ_W-1:0] kmer_read
);
  import kce_pkg::*;

  logic       push;
  base_item_t push_item;
  logic       queue_full;
  logic       pop;
  logic       not_empty;
  base_item_t head_item;

  assign cfg_ready = 1'b1;

  kce_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base_char   (base_char),
    .read_start  (read_start),
    .read_number (read_number),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  kce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  kce_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (not_empty),
    .item           (head_item),
    .pop            (pop),
    .cfg_valid      (cfg_valid),
    .cfg_k          (kmer_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .canonical_kmer (canonical_kmer),
    .kmer_read      (kmer_read)
  );

endmodule
